// ===== sv/fdhe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Footswitch debounce package
// Shared widths, event codes and the event code mapping for the footswitch
// debounce and hold event unit.
// ----------------------------------------------------------------------------
package fdhe_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int TIME_W   = 32;
    localparam int MS_CFG_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int TDATA_W  = 40;

    typedef logic [2:0] t_ev;

    localparam t_ev EV_NONE = 3'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 8'd1;

    typedef enum logic [1:0] {
        KIND_PRESS    = 2'd1,
        KIND_HOLD     = 2'd2,
        KIND_HOLD_REL = 2'd3
    } t_kind;

    typedef struct packed {
        logic              push;
        t_kind             kind;
        logic [TIME_W-1:0] held;
    } t_sw_out;

    // Switch 0 uses codes 1 to 3, switch 1 uses codes 4 to 6.
    function automatic t_ev ev_code(input logic sw, input t_kind kind);
        t_ev base;
        base = sw ? 3'd3 : 3'd0;
        return base + {1'b0, kind};
    endfunction

endpackage
`default_nettype wire

// ===== sv/fdhe_switch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Footswitch debounce channel
// Debounces one raw switch level, tracks the open press and its hold, and
// reports the event it raises and the held duration after the update.
// ----------------------------------------------------------------------------
module fdhe_switch (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_fire,
    input  wire logic                           i_raw,
    input  wire logic [fdhe_pkg::TIME_W-1:0]    i_now,
    input  wire logic [fdhe_pkg::MS_CFG_W-1:0]  i_debounce_ms,
    input  wire logic [fdhe_pkg::MS_CFG_W-1:0]  i_hold_ms,
    output fdhe_pkg::t_sw_out                   o_res
);
    import fdhe_pkg::*;

    logic              r_last_raw, n_last_raw;
    logic              r_stable, n_stable;
    logic              r_press_open, n_press_open;
    logic              r_hold_done, n_hold_done;
    logic [TIME_W-1:0] r_change_time, n_change_time;
    logic [TIME_W-1:0] r_press_time, n_press_time;
    logic [TIME_W-1:0] stable_for;
    logic [TIME_W-1:0] pressed_for;
    logic              push;
    t_kind             kind;

    always_comb begin
        n_last_raw    = r_last_raw;
        n_change_time = r_change_time;
        n_stable      = r_stable;
        n_press_open  = r_press_open;
        n_hold_done   = r_hold_done;
        n_press_time  = r_press_time;
        push          = 1'b0;
        kind          = KIND_PRESS;

        if (i_raw != r_last_raw) begin
            n_last_raw    = i_raw;
            n_change_time = i_now;
        end
        stable_for = i_now - n_change_time;
        if (stable_for >= {{(TIME_W-MS_CFG_W){1'b0}}, i_debounce_ms} && i_raw != r_stable) begin
            n_stable = i_raw;
            if (i_raw) begin
                n_press_open = 1'b1;
                n_hold_done  = 1'b0;
                n_press_time = i_now;
            end else begin
                if (r_press_open) begin
                    push = 1'b1;
                    kind = r_hold_done ? KIND_HOLD_REL : KIND_PRESS;
                end
                n_press_open = 1'b0;
            end
        end
        pressed_for = i_now - n_press_time;
        if (n_press_open && !n_hold_done &&
            pressed_for >= {{(TIME_W-MS_CFG_W){1'b0}}, i_hold_ms}) begin
            n_hold_done = 1'b1;
            push        = 1'b1;
            kind        = KIND_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_press_open  <= 1'b0;
            r_hold_done   <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
        end else if (i_fire) begin
            r_last_raw    <= n_last_raw;
            r_stable      <= n_stable;
            r_press_open  <= n_press_open;
            r_hold_done   <= n_hold_done;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
        end
    end

    assign o_res.push = push;
    assign o_res.kind = kind;
    assign o_res.held = n_press_open ? pressed_for : '0;

endmodule
`default_nettype wire

// ===== sv/fdhe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Footswitch event ring
// Ring queue that takes up to two events per request, drops events when
// full, and pops the oldest event after the pushes of the same request.
// ----------------------------------------------------------------------------
module fdhe_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic          i_push0,
    input  wire fdhe_pkg::t_ev i_code0,
    input  wire logic          i_push1,
    input  wire fdhe_pkg::t_ev i_code1,
    input  wire logic          i_pop,
    output fdhe_pkg::t_ev      o_pop_code,
    output logic               o_pending
);
    import fdhe_pkg::*;

    localparam logic [QIDX_W-1:0] LAST_IDX = QIDX_W'(QUEUE_DEPTH - 1);

    t_ev               r_ring [QUEUE_DEPTH];
    logic [QIDX_W-1:0] r_head, r_tail;
    logic [QIDX_W-1:0] head1, head2, n_tail;
    logic              ok0, ok1, non_empty, do_pop;
    t_ev               rd_code;

    function automatic logic [QIDX_W-1:0] ring_next(input logic [QIDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        ok0       = i_push0 && (ring_next(r_head) != r_tail);
        head1     = ok0 ? ring_next(r_head) : r_head;
        ok1       = i_push1 && (ring_next(head1) != r_tail);
        head2     = ok1 ? ring_next(head1) : head1;
        non_empty = head2 != r_tail;
        do_pop    = i_pop && non_empty;
        if (r_tail == r_head) begin
            rd_code = ok0 ? i_code0 : i_code1;
        end else begin
            rd_code = r_ring[r_tail];
        end
        n_tail     = do_pop ? ring_next(r_tail) : r_tail;
        o_pop_code = do_pop ? rd_code : EV_NONE;
        o_pending  = head2 != n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_fire) begin
            r_head <= head2;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && ok0) begin
            r_ring[r_head] <= i_code0;
        end
        if (i_fire && ok1) begin
            r_ring[head1] <= i_code1;
        end
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= LAST_IDX) && (r_tail <= LAST_IDX))
        else $error("ring pointer out of range");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && do_pop) |-> (o_pop_code != EV_NONE))
        else $error("popped an empty event code");

    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_fire)) |-> ($stable(r_head) && $stable(r_tail)))
        else $error("ring pointers moved without a request");

endmodule
`default_nettype wire

// ===== sv/footswitch_debounce_hold_events_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Footswitch debounce and hold event unit
// Debounces two footswitches, raises press, hold and hold-release events into
// a ring queue, pops on request and reports the queried held duration.
//
// Channel   Direction  Handshake            Content
// s_axis    in         tvalid/tready        time, raw levels, pop, query
// m_axis    out        tvalid/tready        popped event, pending, held time
// cfg       in         valid/ready          register index and data
//
// A request is accepted into the input register and its result is then
// registered in the output register by the single update pass over both
// switches and the ring; one request per cycle while the output is taken.
// Reset is synchronous and active low and clears all control state.
// A stalled output holds its result; the input register then holds one more
// request and the input stalls until the output is taken.
// ----------------------------------------------------------------------------
module footswitch_debounce_hold_events_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [31:0] now_ms, [32] raw_a, [33] raw_b, [34] pop_req, [35] query_switch
    input  wire logic [fdhe_pkg::TDATA_W-1:0]    i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [2:0] event_code, [3] pending, [35:4] held_ms
    output logic [fdhe_pkg::TDATA_W-1:0]         o_m_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fdhe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fdhe_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import fdhe_pkg::*;

    logic [MS_CFG_W-1:0] r_debounce_ms, r_hold_ms;
    logic                r_in_valid;
    logic [TIME_W-1:0]   r_now;
    logic                r_raw_a, r_raw_b, r_pop, r_query;
    logic                r_out_valid;
    t_ev                 r_out_code;
    logic                r_out_pending;
    logic [TIME_W-1:0]   r_out_held;
    logic                fire;
    t_sw_out             sw_a, sw_b;
    t_ev                 pop_code;
    logic                pending;

    assign fire        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= 16'd20;
            r_hold_ms     <= 16'd500;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                CFG_HOLD:     r_hold_ms     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_now   <= i_s_tdata[31:0];
            r_raw_a <= i_s_tdata[32];
            r_raw_b <= i_s_tdata[33];
            r_pop   <= i_s_tdata[34];
            r_query <= i_s_tdata[35];
        end
    end

    fdhe_switch u_sw_a (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_raw         (r_raw_a),
        .i_now         (r_now),
        .i_debounce_ms (r_debounce_ms),
        .i_hold_ms     (r_hold_ms),
        .o_res         (sw_a)
    );

    fdhe_switch u_sw_b (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_raw         (r_raw_b),
        .i_now         (r_now),
        .i_debounce_ms (r_debounce_ms),
        .i_hold_ms     (r_hold_ms),
        .o_res         (sw_b)
    );

    fdhe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_push0    (sw_a.push),
        .i_code0    (ev_code(1'b0, sw_a.kind)),
        .i_push1    (sw_b.push),
        .i_code1    (ev_code(1'b1, sw_b.kind)),
        .i_pop      (r_pop),
        .o_pop_code (pop_code),
        .o_pending  (pending)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_code    <= pop_code;
            r_out_pending <= pending;
            r_out_held    <= r_query ? sw_b.held : sw_a.held;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_held, r_out_pending, r_out_code};

endmodule
`default_nettype wire
